[sv/rgb_preset_crossfader_top_assert.svh]
// assertion macros for the crossfader top level
// clocked on clock, disabled while reset is high
`ifndef RGB_PRESET_CROSSFADER_TOP_ASSERT_SVH
`define RGB_PRESET_CROSSFADER_TOP_ASSERT_SVH

// same-cycle implication
`define RPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crossfader assertion failed");

// next-cycle implication
`define RPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crossfader assertion failed");

`endif

[sv/rpc_pkg.sv]
// shared types and constants for the rgb preset crossfader
// no dependencies
package rpc_pkg;

   localparam int MaxPresetsDef = 5;
   localparam int NumCh         = 3;
   localparam int NumColours    = 5;

   typedef enum logic [2:0] {
      REG_PRESET_A     = 3'd0,
      REG_PRESET_B     = 3'd1,
      REG_PRESET_C     = 3'd2,
      REG_PRESET_D     = 3'd3,
      REG_PRESET_E     = 3'd4,
      REG_CYCLE_LEN    = 3'd5,
      REG_STEP_PERIOD  = 3'd6,
      REG_HOLD_TIME    = 3'd7
   } reg_index_type;

   localparam logic [23:0] PresetAReset     = 24'h5050FF;
   localparam logic [23:0] PresetBReset     = 24'h50FF50;
   localparam logic [23:0] PresetCReset     = 24'h00FF32;
   localparam logic [23:0] PresetDReset     = 24'h0000FF;
   localparam logic [23:0] PresetEReset     = 24'h7800FF;
   localparam logic [2:0]  CycleLenReset    = 3'd5;
   localparam logic [15:0] StepPeriodReset  = 16'd80;
   localparam logic [15:0] HoldTimeReset    = 16'd9001;

   typedef struct packed {
      logic [NumColours-1:0][23:0] colour;
      logic [2:0]                  cycle_len;
      logic [15:0]                 step_period;
      logic [15:0]                 hold_time;
   } cfg_type;

   typedef struct packed {
      logic [NumCh-1:0][7:0] level;
      logic [NumCh-1:0]      matched;
      logic [2:0]            preset;
      logic                  hold;
   } state_type;

endpackage

[sv/rgb_preset_crossfader_top.sv]
// a req transfer is taken into the input register; its update then loads the state registers and sets rsp valid
// throughput: one item per cycle while rsp is not stalled, set by the input register feeding the state update
// the state registers double as the result register and hold while rsp is stalled
// synchronous active-high reset clears state, levels, valids and loads register defaults
// csr writes are taken every cycle
`include "rgb_preset_crossfader_top_assert.svh"

// top level: input register, configuration registers and fade core
// depends on rpc_pkg, rpc_csr, rpc_core
module rgb_preset_crossfader_top import rpc_pkg::*; #(
   parameter int MAX_PRESETS = MaxPresetsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] advance, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] level_ch0, [15:8] level_ch1, [23:16] level_ch2,
                                    // [26:24] preset_index, [27] holding, [31:28] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic      in_valid_ff, in_valid_in;
   logic      in_adv_ff, in_adv_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;
   logic      update;
   cfg_type   cfg;
   state_type state;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign update     = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || update;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !update);
   assign in_adv_in    = (req_tvalid && req_tready) ? req_tdata[0] : in_adv_ff;
   assign out_valid_in = update || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_adv_ff <= in_adv_in;
   end

   rpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (reg_index_type'(csr_index)),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   rpc_core #(
      .MAX_PRESETS (MAX_PRESETS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .update  (update),
      .advance (in_adv_ff),
      .cfg     (cfg),
      .state   (state)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, state.hold, state.preset,
                        state.level[2], state.level[1], state.level[0]};

   localparam logic [2:0] PresetLimit = 3'(MAX_PRESETS);

   `RPC_ASSERT_NOW(a_preset_in_range, rsp_tvalid, rsp_tdata[26:24] < PresetLimit)
   `RPC_ASSERT_NOW(a_hold_all_matched, state.hold, &state.matched)
   `RPC_ASSERT_NEXT(a_update_gives_result, update, rsp_tvalid)

endmodule

[sv/rpc_csr.sv]
// configuration register file for the crossfader
// depends on rpc_pkg
module rpc_csr import rpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  reg_index_type wr_index,
   input  logic [23:0]   wr_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_PRESET_A:     cfg_in.colour[0]    = wr_data;
            REG_PRESET_B:     cfg_in.colour[1]    = wr_data;
            REG_PRESET_C:     cfg_in.colour[2]    = wr_data;
            REG_PRESET_D:     cfg_in.colour[3]    = wr_data;
            REG_PRESET_E:     cfg_in.colour[4]    = wr_data;
            REG_CYCLE_LEN:    cfg_in.cycle_len    = wr_data[2:0];
            REG_STEP_PERIOD:  cfg_in.step_period  = wr_data[15:0];
            REG_HOLD_TIME:    cfg_in.hold_time    = wr_data[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.colour[0]    <= PresetAReset;
         cfg_ff.colour[1]    <= PresetBReset;
         cfg_ff.colour[2]    <= PresetCReset;
         cfg_ff.colour[3]    <= PresetDReset;
         cfg_ff.colour[4]    <= PresetEReset;
         cfg_ff.cycle_len    <= CycleLenReset;
         cfg_ff.step_period  <= StepPeriodReset;
         cfg_ff.hold_time    <= HoldTimeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/rpc_core.sv]
// fade/hold state and its single-pass update for one tick slot
// depends on rpc_pkg
module rpc_core import rpc_pkg::*; #(
   parameter int MAX_PRESETS = MaxPresetsDef
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      update,
   input  logic      advance,
   input  cfg_type   cfg,
   output state_type state
);

   localparam logic [2:0] CountMax = 3'(MAX_PRESETS);

   logic [NumCh-1:0][7:0] level_ff, level_in;
   logic [NumCh-1:0]      matched_ff, matched_in;
   logic [2:0]            preset_ff, preset_in;
   logic                  hold_ff, hold_in;
   logic [15:0]           wait_ff, wait_in;

   logic [2:0]            eff_count;
   logic [3:0]            nxt_sum;
   logic [2:0]            next_idx;
   logic                  expire;
   logic                  go_next;
   logic                  go_hold;
   logic [2:0]            sel_idx;
   logic [NumCh-1:0]      flags_base;
   logic [23:0]           colour;

   always_comb begin
      if (cfg.cycle_len == 3'd0) begin
         eff_count = 3'd1;
      end else if (cfg.cycle_len > CountMax) begin
         eff_count = CountMax;
      end else begin
         eff_count = cfg.cycle_len;
      end
   end

   assign nxt_sum  = {1'b0, preset_ff} + 4'd1;
   assign next_idx = (nxt_sum >= {1'b0, eff_count}) ? 3'd0 : nxt_sum[2:0];
   assign expire   = (wait_ff <= 16'd1);
   // a hold that ends, or a zero-length hold, moves straight to the next preset
   assign go_next  = hold_ff || ((&matched_ff) && (cfg.hold_time == 16'd0));
   assign go_hold  = !hold_ff && (&matched_ff) && (cfg.hold_time != 16'd0);
   assign sel_idx    = go_next ? next_idx : preset_ff;
   assign flags_base = go_next ? '0 : matched_ff;

   always_comb begin
      case (reg_index_type'(sel_idx))
         REG_PRESET_A: colour = cfg.colour[0];
         REG_PRESET_B: colour = cfg.colour[1];
         REG_PRESET_C: colour = cfg.colour[2];
         REG_PRESET_D: colour = cfg.colour[3];
         REG_PRESET_E: colour = cfg.colour[4];
         default:      colour = cfg.colour[0];
      endcase
   end

   always_comb begin
      level_in   = level_ff;
      matched_in = matched_ff;
      preset_in  = preset_ff;
      hold_in    = hold_ff;
      wait_in    = wait_ff;
      if (update && advance) begin
         if (!expire) begin
            wait_in = wait_ff - 16'd1;
         end else if (go_hold) begin
            hold_in = 1'b1;
            wait_in = cfg.hold_time;
         end else begin
            preset_in  = sel_idx;
            hold_in    = 1'b0;
            matched_in = flags_base;
            wait_in    = cfg.step_period;
            for (int c = 0; c < NumCh; c++) begin
               if (!flags_base[c]) begin
                  if (level_ff[c] < colour[8*c +: 8]) begin
                     level_in[c] = level_ff[c] + 8'd1;
                  end else if (level_ff[c] > colour[8*c +: 8]) begin
                     level_in[c] = level_ff[c] - 8'd1;
                  end else begin
                     matched_in[c] = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         matched_ff <= '0;
         preset_ff  <= '0;
         hold_ff    <= 1'b0;
         wait_ff    <= '0;
      end else begin
         level_ff   <= level_in;
         matched_ff <= matched_in;
         preset_ff  <= preset_in;
         hold_ff    <= hold_in;
         wait_ff    <= wait_in;
      end
   end

   assign state.level   = level_ff;
   assign state.matched = matched_ff;
   assign state.preset  = preset_ff;
   assign state.hold    = hold_ff;

endmodule

[tb/sv/tb_rgb_preset_crossfader_top.sv]
// self-checking testbench for rgb_preset_crossfader_top: directed table, then random phases
// known rows use table values, others its crossfade model; depends on rpc_pkg and the top level
module tb_rgb_preset_crossfader_top import rpc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // same layout as rsp_tdata[27:0]: holding, preset, ch2, ch1, ch0 from the top bit down
   typedef struct packed {
      logic       holding;
      logic [2:0] preset;
      logic [7:0] ch2;
      logic [7:0] ch1;
      logic [7:0] ch0;
   } fade_out_type;

   typedef enum logic [1:0] { ROW_CSR, ROW_TICK, ROW_TICK_KNOWN } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type idx;
      logic [23:0]   value;
      logic          adv;
      fade_out_type  want;
   } script_row_type;

   localparam int ScriptLen = 37;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [23:0] csr_data = 24'd0;

   bit           calm = 1'b0;
   int unsigned  bad_fields = 0;
   fade_out_type levels_due [$];

   // crossfade model state and its copy of the registers
   logic [23:0]      colours [NumColours] = '{PresetAReset, PresetBReset, PresetCReset,
                                              PresetDReset, PresetEReset};
   logic [2:0]       count_reg = CycleLenReset;
   logic [15:0]      step_reg = StepPeriodReset;
   logic [15:0]      hold_reg = HoldTimeReset;
   logic [7:0]       lvl [NumCh] = '{default: 8'd0};
   logic [NumCh-1:0] lvl_matched = '0;
   logic [2:0]       cur_preset = 3'd0;
   logic [15:0]      wait_left = 16'd0;
   logic             holding_now = 1'b0;

   script_row_type script [ScriptLen] = '{
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b0, 28'h0_00_00_00},   // all dark after reset
      '{ROW_CSR, REG_STEP_PERIOD, 24'h0, 1'b0, 28'h0},                // zero period acts as one
      '{ROW_CSR, REG_HOLD_TIME, 24'h0, 1'b0, 28'h0},
      '{ROW_CSR, REG_PRESET_A, 24'h000201, 1'b0, 28'h0},
      '{ROW_CSR, REG_PRESET_B, 24'h000000, 1'b0, 28'h0},
      '{ROW_CSR, REG_CYCLE_LEN, 24'h2, 1'b0, 28'h0},
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b1, 28'h0_00_01_01},
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b1, 28'h0_00_02_01},
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b1, 28'h0_00_02_01},
      // zero hold: next preset entered and first step taken on the same tick
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b1, 28'h1_00_01_00},
      '{ROW_TICK_KNOWN, REG_PRESET_A, 24'h0, 1'b0, 28'h1_00_01_00},
      // count lowered below the current preset, wrap comes on a later advance
      '{ROW_CSR, REG_CYCLE_LEN, 24'h1, 1'b0, 28'h0},
      '{ROW_CSR, REG_HOLD_TIME, 24'h2, 1'b0, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      // count above the preset maximum clamps to it
      '{ROW_CSR, REG_CYCLE_LEN, 24'h7, 1'b0, 28'h0},
      '{ROW_CSR, REG_PRESET_C, 24'hFF00FF, 1'b0, 28'h0},
      '{ROW_CSR, REG_PRESET_D, 24'hFFFFFF, 1'b0, 28'h0},
      '{ROW_CSR, REG_PRESET_E, 24'h000000, 1'b0, 28'h0},
      '{ROW_CSR, REG_STEP_PERIOD, 24'h3, 1'b0, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b0, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      // zero count behaves as a single preset
      '{ROW_CSR, REG_CYCLE_LEN, 24'h0, 1'b0, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0},
      '{ROW_TICK, REG_PRESET_A, 24'h0, 1'b1, 28'h0}
   };

   rgb_preset_crossfader_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      bad_fields++;
      $display("%0t rsp %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void fade_once();
      logic [23:0] colour_now;
      colour_now = (cur_preset < NumColours) ? colours[cur_preset] : colours[0];
      for (int c = 0; c < NumCh; c++) begin
         if (!lvl_matched[c]) begin
            if (lvl[c] < colour_now[8*c +: 8]) lvl[c]++;
            else if (lvl[c] > colour_now[8*c +: 8]) lvl[c]--;
            else lvl_matched[c] = 1'b1;
         end
      end
      wait_left = step_reg;
   endfunction

   function automatic void enter_next();
      int unsigned span;
      int unsigned nxt;
      span = (count_reg == 3'd0) ? 1 : (count_reg > MaxPresetsDef) ? MaxPresetsDef : count_reg;
      nxt = cur_preset + 1;
      if (nxt >= span) nxt = 0;
      cur_preset = 3'(nxt);
      lvl_matched = '0;
      holding_now = 1'b0;
      fade_once();
   endfunction

   function automatic void advance_fade(input logic adv, output fade_out_type now);
      if (adv) begin
         if (wait_left > 16'd1) wait_left--;
         else if (holding_now) enter_next();
         else if (&lvl_matched) begin
            holding_now = 1'b1;
            wait_left = hold_reg;
            if (wait_left == 16'd0) enter_next();
         end else begin
            fade_once();
         end
      end
      now.ch0 = lvl[0];
      now.ch1 = lvl[1];
      now.ch2 = lvl[2];
      now.preset = cur_preset;
      now.holding = holding_now;
   endfunction

   function automatic void store_reg(input reg_index_type idx, input logic [23:0] value);
      case (idx)
         REG_CYCLE_LEN:    count_reg = value[2:0];
         REG_STEP_PERIOD:  step_reg = value[15:0];
         REG_HOLD_TIME:    hold_reg = value[15:0];
         default:          colours[int'(idx)] = value;
      endcase
   endfunction

   // register values per random phase: phase 6 sweeps white and black, phase 7 the longest waits
   function automatic logic [23:0] phase_value(input reg_index_type idx, input int ph);
      logic [23:0] junk;
      junk = ($urandom_range(3) == 0) ? 24'($urandom) : 24'd0;
      case (idx)
         REG_CYCLE_LEN:
            return {junk[23:3], (ph == 6) ? 3'd2 : 3'($urandom_range(7))};
         REG_STEP_PERIOD:
            return {junk[23:16], (ph == 7) ? 16'hFFFF : 16'($urandom_range(ph == 6 ? 1 : 3))};
         REG_HOLD_TIME:
            return {junk[23:16], (ph == 7) ? 16'hFFFF : 16'($urandom_range(ph == 6 ? 1 : 4))};
         default: begin
            if (ph == 6) return (idx == REG_PRESET_A) ? 24'hFFFFFF : 24'h000000;
            if ($urandom_range(9) == 0) return 24'($urandom);
            // mostly dim colours so fades finish and holds and wraps come up often
            return {8'($urandom_range(6)), 8'($urandom_range(6)), 8'($urandom_range(6))};
         end
      endcase
   endfunction

   // register writes only once every pending result has come back
   task automatic write_reg(input reg_index_type idx, input logic [23:0] value);
      req_tvalid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      store_reg(idx, value);
   endtask

   task automatic push_tick(input logic adv, input bit typed, input fade_out_type typed_want);
      fade_out_type model_out;
      csr_valid <= 1'b0;
      if (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 34) @(posedge clock);
      end
      advance_fade(adv, model_out);
      levels_due.push_back(typed ? typed_want : model_out);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, adv};
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 34);

   always @(posedge clock) begin : rsp_check
      fade_out_type got;
      fade_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[27:0];
         if (levels_due.size() == 0) begin
            flag_mismatch("transfer with nothing pending", rsp_tdata, 0);
         end else begin
            want = levels_due.pop_front();
            if (got.ch0 != want.ch0) flag_mismatch("level_ch0", got.ch0, want.ch0);
            if (got.ch1 != want.ch1) flag_mismatch("level_ch1", got.ch1, want.ch1);
            if (got.ch2 != want.ch2) flag_mismatch("level_ch2", got.ch2, want.ch2);
            if (got.preset != want.preset)
               flag_mismatch("preset_index", got.preset, want.preset);
            if (got.holding != want.holding)
               flag_mismatch("holding", got.holding, want.holding);
            if (rsp_tdata[31:28] != 4'd0) flag_mismatch("pad bits", rsp_tdata[31:28], 0);
         end
      end
   end

   initial begin
      int n_ticks;
      int drain;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) write_reg(script[i].idx, script[i].value);
         else push_tick(script[i].adv, script[i].kind == ROW_TICK_KNOWN, script[i].want);
      end

      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph == 3);
         for (int r = 0; r < 8; r++)
            if (ph == 0 || ph >= 6 || $urandom_range(99) < 50)
               write_reg(reg_index_type'(r), phase_value(reg_index_type'(r), ph));
         n_ticks = (ph == 6) ? 560 : (ph == 7) ? 25 : 70;
         for (int k = 0; k < n_ticks; k++)
            push_tick($urandom_range(99) < ((ph == 6) ? 95 : 80), 1'b0, '0);
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      drain = 0;
      while (levels_due.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (levels_due.size() != 0)
         flag_mismatch("results never returned", levels_due.size(), 0);
      if (bad_fields == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[rgb_preset_crossfader_top.f]
+incdir+sv
sv/rpc_pkg.sv
sv/rpc_csr.sv
sv/rpc_core.sv
sv/rgb_preset_crossfader_top.sv
tb/sv/tb_rgb_preset_crossfader_top.sv
